// ===== sv/radix2_fft_macros.svh =====
// assertion macros
`ifndef RADIX2_FFT_MACROS_SVH
`define RADIX2_FFT_MACROS_SVH

`define R2F_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define R2F_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/r2fft_pkg.sv =====
package r2fft_pkg;
  localparam int unsigned MaxLog2 = 6;
  localparam int unsigned MaxPoints = 64;
  localparam int unsigned AddrW = 6;
  localparam int unsigned CntW = 7;
  localparam int unsigned TwBits = 16;
  localparam int unsigned TwFrac = TwBits - 1;
  localparam int unsigned WordW = 24;
  localparam int unsigned SampW = 16;
  localparam int unsigned LogW = 3;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [TwBits-1:0] tw_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [2*WordW-1:0] cword_t;

  typedef struct packed {
    logic  start;
    word_t ar;
    word_t ai;
    word_t br;
    word_t bi;
    tw_t   wr;
    tw_t   wi;
  } bfly_req_t;

  typedef struct packed {
    logic  done;
    word_t xr;
    word_t xi;
    word_t yr;
    word_t yi;
  } bfly_rsp_t;

  function automatic logic signed [31:0] cos_rom(input logic [4:0] k);
    case (k)
      5'd0:  return 32'sd1073741824;
      5'd1:  return 32'sd1068571464;
      5'd2:  return 32'sd1053110176;
      5'd3:  return 32'sd1027506862;
      5'd4:  return 32'sd992008094;
      5'd5:  return 32'sd946955747;
      5'd6:  return 32'sd892783698;
      5'd7:  return 32'sd830013654;
      5'd8:  return 32'sd759250125;
      5'd9:  return 32'sd681174602;
      5'd10: return 32'sd596538995;
      5'd11: return 32'sd506158392;
      5'd12: return 32'sd410903207;
      5'd13: return 32'sd311690799;
      5'd14: return 32'sd209476638;
      5'd15: return 32'sd105245103;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic logic signed [32:0] cos_q30(input logic [5:0] m);
    logic signed [32:0] v;
    v = '0;
    if (m <= 6'd16) v = 33'(cos_rom(m[4:0]));
    else if (m <= 6'd32) v = -33'(cos_rom(5'(6'd32 - m)));
    else if (m <= 6'd48) v = -33'(cos_rom(5'(m - 6'd32)));
    else v = 33'(cos_rom(5'(7'd64 - {1'b0, m})));
    return v;
  endfunction

  function automatic tw_t to_tw(input logic signed [32:0] v);
    logic signed [33:0] t;
    t = (34'(v) + 34'sd16384) >>> (30 - TwFrac);
    if (t > 34'sd32767) t = 34'sd32767;
    if (t < -34'sd32768) t = -34'sd32768;
    return tw_t'(t);
  endfunction

  function automatic tw_t tw_re(input logic [5:0] m);
    return to_tw(cos_q30(m));
  endfunction

  function automatic tw_t tw_im(input logic [5:0] m);
    return to_tw(-cos_q30(6'(m + 6'd48)));
  endfunction

  function automatic word_t sat24(input logic signed [WordW+1:0] v);
    if (v > 26'sd8388607) return word_t'(24'sh7FFFFF);
    if (v < -26'sd8388608) return word_t'(24'sh800000);
    return word_t'(v);
  endfunction
endpackage

// ===== sv/r2fft_ram.sv =====
module r2fft_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== sv/r2fft_bfly.sv =====
module r2fft_bfly (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  r2fft_pkg::bfly_req_t req_i,
  output r2fft_pkg::bfly_rsp_t rsp_o
);
  import r2fft_pkg::*;

  // one multiplier, four products computed in turn
  logic [2:0] step_q;
  logic busy_q;
  logic done_q;
  word_t xr_q, xi_q, yr_q, yi_q;
  bfly_req_t r_q;
  logic signed [40:0] prod_q;
  logic signed [41:0] accr_q, acci_q;
  logic signed [WordW-1:0] mul_a;
  tw_t mul_b;
  logic signed [41:0] pr, pi;

  always_comb begin
    unique case (step_q)
      3'd0: begin mul_a = r_q.br; mul_b = r_q.wr; end
      3'd1: begin mul_a = r_q.bi; mul_b = r_q.wi; end
      3'd2: begin mul_a = r_q.br; mul_b = r_q.wi; end
      default: begin mul_a = r_q.bi; mul_b = r_q.wr; end
    endcase
  end

  assign pr = (accr_q + 42'sd16384) >>> TwFrac;
  assign pi = (acci_q + 42'sd16384) >>> TwFrac;

  assign rsp_o = {done_q, xr_q, xi_q, yr_q, yi_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == 3'd5) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) r_q <= req_i;
    prod_q <= 41'(mul_a * mul_b);
    if (busy_q) begin
      unique case (step_q)
        3'd1: accr_q <= 42'(prod_q);
        3'd2: accr_q <= accr_q - 42'(prod_q);
        3'd3: acci_q <= 42'(prod_q);
        3'd4: acci_q <= acci_q + 42'(prod_q);
        default: ;
      endcase
    end
    if (busy_q && step_q == 3'd5) begin
      xr_q <= sat24(26'(r_q.ar) + 26'(pr));
      xi_q <= sat24(26'(r_q.ai) + 26'(pi));
      yr_q <= sat24(26'(r_q.ar) - 26'(pr));
      yi_q <= sat24(26'(r_q.ai) - 26'(pi));
    end
  end
endmodule

// ===== sv/radix2_fft.sv =====
// after the final sample of a frame, (N/2)*log2(N) butterflies run serialized through one multiplier,
// then N bins are emitted in index order, subject to output stalls
// throughput: N samples load one per cycle while cfg_valid_i is low; no sample is taken while computing or emitting
// reset: points_log2 becomes 6, load count clears, sample memory is undefined
// a write to points_log2 drops a partly loaded frame
module radix2_fft (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [r2fft_pkg::LogW-1:0] cfg_data_i,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic signed [r2fft_pkg::SampW-1:0] sample_re_i,
  input  logic signed [r2fft_pkg::SampW-1:0] sample_im_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output logic signed [r2fft_pkg::WordW-1:0] bin_re_o,
  output logic signed [r2fft_pkg::WordW-1:0] bin_im_o,
  output logic [r2fft_pkg::AddrW-1:0] bin_index_o,
  output logic last_bin_o
);
  import r2fft_pkg::*;
  `include "radix2_fft_macros.svh"

  typedef enum logic [3:0] {
    S_LOAD, S_RDA, S_RDB, S_WAITA, S_GOT, S_BF, S_WRA, S_WRB, S_ORD, S_OWAIT, S_OUT
  } state_e;

  state_e state_q;
  logic [LogW-1:0] plog_q;
  logic [LogW-1:0] lg;
  logic [CntW-1:0] cnt_q;
  logic [LogW-1:0] stg_q;
  logic [AddrW-1:0] bf_q;
  addr_t ia, ib, lrev;
  logic [AddrW-1:0] jm;
  logic [5:0] tm;
  logic [CntW-1:0] npts;
  word_t ar_q, ai_q;
  bfly_req_t req;
  bfly_rsp_t rsp;

  logic we;
  addr_t waddr, raddr;
  cword_t wdata, rdata;

  always_comb begin
    lg = plog_q;
    if (lg == '0) lg = LogW'(1);
    if (lg > LogW'(MaxLog2)) lg = LogW'(MaxLog2);
  end
  assign npts = CntW'(1) << lg;

  always_comb begin
    lrev = '0;
    for (int i = 0; i < AddrW; i++) begin
      if (i < int'(lg)) lrev[int'(lg) - 1 - i] = cnt_q[i];
    end
  end

  // butterfly bf_q of stage stg_q (1-based), half = 2^(stg-1)
  always_comb begin
    logic [AddrW-1:0] hmask;
    logic [AddrW-1:0] grp;
    hmask = AddrW'((7'd1 << (stg_q - 3'd1)) - 7'd1);
    jm = bf_q & hmask;
    grp = bf_q & ~hmask;
    ia = AddrW'({grp, 1'b0}) | jm;
    ib = ia | AddrW'(7'd1 << (stg_q - 3'd1));
    tm = 6'(jm << (3'(MaxLog2) - stg_q));
  end

  always_comb begin
    req.start = (state_q == S_GOT);
    req.ar = ar_q;
    req.ai = ai_q;
    req.br = word_t'(rdata[2*WordW-1:WordW]);
    req.bi = word_t'(rdata[WordW-1:0]);
    req.wr = tw_re(tm);
    req.wi = tw_im(tm);
  end

  r2fft_bfly u_bfly (.clk_i, .rst_ni, .req_i(req), .rsp_o(rsp));

  always_comb begin
    we = 1'b0;
    waddr = ia;
    wdata = {rsp.xr, rsp.xi};
    raddr = ia;
    unique case (state_q)
      S_LOAD: begin
        we = in_valid_i && !cfg_valid_i;
        waddr = lrev;
        wdata = {WordW'(sample_re_i), WordW'(sample_im_i)};
      end
      S_RDA: raddr = ia;
      S_RDB, S_WAITA, S_GOT: raddr = ib;
      S_WRA: begin we = 1'b1; waddr = ia; end
      S_WRB: begin we = 1'b1; waddr = ib; wdata = {rsp.yr, rsp.yi}; end
      default: raddr = cnt_q[AddrW-1:0];
    endcase
  end

  r2fft_ram #(.Width(2*WordW), .Depth(MaxPoints)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  assign in_stall_o = (state_q != S_LOAD) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      plog_q <= LogW'(MaxLog2);
      cnt_q <= '0;
      stg_q <= LogW'(1);
      bf_q <= '0;
      ar_q <= '0;
      ai_q <= '0;
      out_valid_o <= 1'b0;
      bin_re_o <= '0;
      bin_im_o <= '0;
      bin_index_o <= '0;
      last_bin_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (cfg_valid_i) begin
            plog_q <= cfg_data_i;
            cnt_q <= '0;
          end else if (in_valid_i) begin
            if (cnt_q + CntW'(1) == npts) begin
              cnt_q <= '0;
              stg_q <= LogW'(1);
              bf_q <= '0;
              state_q <= S_RDA;
            end else cnt_q <= cnt_q + CntW'(1);
          end
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          ar_q <= word_t'(rdata[2*WordW-1:WordW]);
          ai_q <= word_t'(rdata[WordW-1:0]);
          state_q <= S_WAITA;
        end
        S_WAITA: state_q <= S_GOT;
        S_GOT: state_q <= S_BF;
        S_BF: if (rsp.done) state_q <= S_WRA;
        S_WRA: state_q <= S_WRB;
        S_WRB: begin
          if (CntW'(bf_q) + CntW'(1) == (npts >> 1)) begin
            bf_q <= '0;
            if (stg_q == lg) begin
              cnt_q <= '0;
              state_q <= S_ORD;
            end else begin
              stg_q <= stg_q + LogW'(1);
              state_q <= S_RDA;
            end
          end else begin
            bf_q <= bf_q + AddrW'(1);
            state_q <= S_RDA;
          end
        end
        S_ORD: state_q <= S_OWAIT;
        S_OWAIT: begin
          out_valid_o <= 1'b1;
          bin_re_o <= word_t'(rdata[2*WordW-1:WordW]);
          bin_im_o <= word_t'(rdata[WordW-1:0]);
          bin_index_o <= cnt_q[AddrW-1:0];
          last_bin_o <= (cnt_q + CntW'(1) == npts);
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            out_valid_o <= 1'b0;
            if (last_bin_o) begin
              cnt_q <= '0;
              state_q <= S_LOAD;
            end else begin
              cnt_q <= cnt_q + CntW'(1);
              state_q <= S_ORD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  `R2F_ASSERT_IMP(a_no_in_busy, state_q != S_LOAD, in_stall_o)
  `R2F_ASSERT_IMP(a_out_only_emit, out_valid_o, state_q == S_OUT)
  `R2F_ASSERT_IMP(a_cnt_range, state_q == S_LOAD, cnt_q < npts)
  `R2F_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(bin_re_o))
endmodule

// ===== sim/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import r2fft_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned LongHold = 300;
  localparam int unsigned TargetSamples = 210;

  typedef struct {
    longint re;
    longint im;
    int unsigned idx;
    bit last;
  } bin_t;

  class bin_scoreboard;
    int unsigned log2_reg;
    int unsigned loaded;
    longint fft_re[MaxPoints];
    longint fft_im[MaxPoints];
    bin_t pending[$];
    int unsigned mismatches;
    int unsigned bins_checked;
    int unsigned frames_done;

    function new();
      log2_reg = 6;
      loaded = 0;
      mismatches = 0;
      bins_checked = 0;
      frames_done = 0;
    endfunction

    function int unsigned eff_log2();
      if (log2_reg < 1) return 1;
      if (log2_reg > MaxLog2) return MaxLog2;
      return log2_reg;
    endfunction

    function void write_length(int unsigned v);
      log2_reg = v;
      loaded = 0;
    endfunction

    function longint cos_fix(int unsigned m);
      longint quarter[17] = '{1073741824, 1068571464, 1053110176, 1027506862,
        992008094, 946955747, 892783698, 830013654, 759250125, 681174602,
        596538995, 506158392, 410903207, 311690799, 209476638, 105245103, 0};
      m = m % 64;
      if (m <= 16) return quarter[m];
      if (m <= 32) return -quarter[32 - m];
      if (m <= 48) return -quarter[m - 32];
      return quarter[64 - m];
    endfunction

    function longint quantize(longint v);
      longint t;
      t = (v + (64'sd1 <<< 14)) >>> 15;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
      return t;
    endfunction

    function longint clip24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
    endfunction

    function void transform(int unsigned lg);
      int unsigned n;
      int unsigned half;
      int unsigned ia;
      int unsigned ib;
      longint wr;
      longint wi;
      longint pr;
      longint pi;
      longint ar;
      longint ai;
      n = 1 << lg;
      for (int unsigned s = 1; s <= lg; s++) begin
        half = 1 << (s - 1);
        for (int unsigned base = 0; base < n; base += 2 * half) begin
          for (int unsigned j = 0; j < half; j++) begin
            ia = base + j;
            ib = ia + half;
            wr = quantize(cos_fix(j << (MaxLog2 - s)));
            wi = quantize(-cos_fix((j << (MaxLog2 - s)) + 48));
            pr = (fft_re[ib] * wr - fft_im[ib] * wi + (64'sd1 <<< 14)) >>> 15;
            pi = (fft_re[ib] * wi + fft_im[ib] * wr + (64'sd1 <<< 14)) >>> 15;
            ar = fft_re[ia];
            ai = fft_im[ia];
            fft_re[ia] = clip24(ar + pr);
            fft_im[ia] = clip24(ai + pi);
            fft_re[ib] = clip24(ar - pr);
            fft_im[ib] = clip24(ai - pi);
          end
        end
      end
    endfunction

    function void note_sample(logic signed [15:0] re, logic signed [15:0] im);
      int unsigned lg;
      int unsigned n;
      int unsigned addr;
      bin_t b;
      lg = eff_log2();
      n = 1 << lg;
      if (loaded >= n) loaded = 0;
      addr = 0;
      for (int unsigned i = 0; i < lg; i++) addr |= ((loaded >> i) & 1) << (lg - 1 - i);
      fft_re[addr] = re;
      fft_im[addr] = im;
      loaded++;
      if (loaded < n) return;
      transform(lg);
      for (int unsigned k = 0; k < n; k++) begin
        b.re = fft_re[k];
        b.im = fft_im[k];
        b.idx = k;
        b.last = (k == n - 1);
        pending.push_back(b);
      end
      loaded = 0;
      frames_done++;
    endfunction

    function void check_bin(longint re, longint im, int unsigned idx, bit last);
      bin_t b;
      bins_checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected bin %0d re %0d im %0d", idx, re, im);
        return;
      end
      b = pending.pop_front();
      if (b.re != re || b.im != im || b.idx != idx || b.last != last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("bin mismatch: exp k=%0d re=%0d im=%0d last=%0d, got k=%0d re=%0d im=%0d last=%0d",
                   b.idx, b.re, b.im, b.last, idx, re, im, last);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [LogW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [SampW-1:0] sample_re_i = '0;
  logic signed [SampW-1:0] sample_im_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [WordW-1:0] bin_re_o;
  logic signed [WordW-1:0] bin_im_o;
  logic [AddrW-1:0] bin_index_o;
  logic last_bin_o;

  bin_scoreboard sb = new();
  bit quiet;
  bit hold_req;
  int unsigned samples_sent;
  int unsigned cycles = 0;

  radix2_fft u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i(cfg_data_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sample_re_i(sample_re_i),
    .sample_im_i(sample_im_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .bin_re_o(bin_re_o),
    .bin_im_o(bin_im_o),
    .bin_index_o(bin_index_o),
    .last_bin_o(last_bin_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // result side: optional random stall before each transfer
  initial begin
    int unsigned gap;
    bit held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (hold_req && !held) begin
        gap = LongHold;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      sb.check_bin(bin_re_o, bin_im_o, bin_index_o, last_bin_o);
    end
  end

  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_re_i <= re;
    sample_im_i <= im;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_sample(re, im);
    samples_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_length(int unsigned v);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= LogW'(v);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.write_length(v);
  endtask

  function automatic logic signed [15:0] draw_value(int unsigned style);
    case (style)
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return 16'($signed($urandom_range(0, 128)) - 64);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int unsigned count, int unsigned style);
    for (int unsigned i = 0; i < count; i++) send_sample(draw_value(style), draw_value(style));
  endtask

  initial begin
    int unsigned lg;
    int unsigned n;
    quiet = 1'b0;
    hold_req = 1'b0;
    samples_sent = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset length, then directed frames
    send_frame(64, 2);
    write_length(1);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sh7FFF, 16'sh8000);
    write_length(0);
    send_sample(16'sh8000, 16'sh8000);
    send_sample(16'sh8000, 16'sh7FFF);
    write_length(2);
    send_sample(16'sh0001, 16'sh0000);
    send_sample(16'sh0000, 16'shFFFF);
    send_sample(16'sh7FFF, 16'sh8000);
    send_sample(16'sh0000, 16'sh0000);
    write_length(3);
    send_frame(3, 2);
    write_length(3);
    send_frame(8, 0);
    write_length(7);

    // long output hold while the next frame is offered
    hold_req = 1'b1;
    send_frame(64, 2);
    send_frame(16, 1);

    while (samples_sent < TargetSamples) begin
      lg = ($urandom_range(0, 7) == 0) ? 5 : $urandom_range(0, 4);
      write_length(lg);
      n = 1 << ((lg < 1) ? 1 : lg);
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) send_frame($urandom_range(1, n - 1), $urandom_range(0, 2));
      else send_frame(n * ((n > 16) ? 1 : $urandom_range(1, 2)),
                      $urandom_range(0, 5) == 0 ? 1 : ($urandom_range(0, 5) == 0 ? 0 : 2));
    end
    quiet = 1'b0;

    drain();
    repeat (200) @(posedge clk_i);
    $display("samples sent %0d, frames %0d, bins checked %0d, lengths 2..64 incl. clamped codes",
             samples_sent, sb.frames_done, sb.bins_checked);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("mismatches %0d, bins still owed %0d", sb.mismatches, sb.pending.size());
      $display("FAIL");
    end
    $finish;
  end
endmodule
